[rtl/thermostat_average_hysteresis_defines.svh]
`ifndef THERMOSTAT_AVERAGE_HYSTERESIS_DEFINES_SVH
`define THERMOSTAT_AVERAGE_HYSTERESIS_DEFINES_SVH

// Concurrent check on an explicit clock and synchronous reset.
`define THAH_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define THAH_ASSERT(label, prop, msg) `THAH_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

[rtl/thah_pkg.sv]
package thah_pkg;

   localparam int ADC_W      = 10;
   localparam int TEMP_W     = 8;
   localparam int TARGET_W   = 7;
   localparam int BAND_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int NUM_READINGS_DEF = 10;
   localparam int BLINK_TICKS_DEF  = 10;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd60;
   localparam logic [BAND_W-1:0]   BAND_RESET   = 5'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_BAND      = 2'd2;

   // degrees = floor(adc * 0.488), exact for every 10-bit code as (adc * 511706) >> 20
   localparam int DEG_MULT_W = 19;
   localparam logic [DEG_MULT_W-1:0] DEG_MULT = 19'd511706;
   localparam int DEG_SHIFT = 20;
   localparam int PROD_W    = ADC_W + DEG_MULT_W;
   localparam int DEG_W     = PROD_W - DEG_SHIFT;

   function automatic logic [TEMP_W-1:0] to_degrees(input logic [ADC_W-1:0] adc);
      logic [PROD_W-1:0] prod;
      logic [DEG_W-1:0]  deg;
      prod = PROD_W'(adc) * PROD_W'(DEG_MULT);
      deg  = prod[PROD_W-1:DEG_SHIFT];
      if (deg[DEG_W-1:TEMP_W] != '0) begin
         return '1;
      end
      return deg[TEMP_W-1:0];
   endfunction

endpackage

[rtl/thah_alu.sv]
module thah_alu #(
   parameter int W = 12
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] y,
   output logic         cout
);

   logic [W-1:0] b_eff;

   assign b_eff = sub ? ~b : b;
   assign {cout, y} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

[rtl/thah_ring.sv]
module thah_ring #(
   parameter int NUM_READINGS = 10,
   parameter int IDX_W = 4
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [thah_pkg::TEMP_W-1:0] wr_data,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [thah_pkg::TEMP_W-1:0] rd_data
);
   import thah_pkg::*;

   logic [TEMP_W-1:0] mem [NUM_READINGS];
   logic [TEMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/thermostat_average_hysteresis.sv]
// Bang-bang thermostat with hysteresis. Each req transaction is one 100 ms tick
// carrying a 10-bit ADC code; it is converted to degrees (floor of code * 0.488,
// saturated at 255) and stored in a ring of the last NUM_READINGS readings. With
// control enabled the stored readings are averaged and the heater/cooler switch
// around the target with the hysteresis band; the LED is set at a heater-to-cooler
// switch and toggles every BLINK_TICKS heating ticks. Each tick gives exactly one
// rsp transaction. One adder/subtractor does the sum and the division: one add per
// stored reading, then one quotient bit per cycle for the average (SUM_W bits,
// 12 at the defaults). A tick runs through conversion, the sum, a tail add, the
// division, the control step and the rsp hand-off; with control disabled it goes
// from conversion straight to the hand-off. req_ready is high only between ticks;
// a finished result may still wait in the rsp register meanwhile. csr writes are
// taken at any time and must be made only while the block is idle; indexes beyond
// the register list are ignored. No clearing pass follows reset.
`include "thermostat_average_hysteresis_defines.svh"

module thermostat_average_hysteresis #(
   parameter int NUM_READINGS = thah_pkg::NUM_READINGS_DEF,
   parameter int BLINK_TICKS  = thah_pkg::BLINK_TICKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [thah_pkg::ADC_W-1:0]      req_adc_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_heater_drive,
   output logic                            rsp_cooler_drive,
   output logic                            rsp_status_led,
   output logic [thah_pkg::TEMP_W-1:0]     rsp_current_temp,
   output logic [thah_pkg::TEMP_W-1:0]     rsp_average_temp,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [thah_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [thah_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import thah_pkg::*;

   localparam int IDX_W  = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
   localparam int CNT_W  = $clog2(NUM_READINGS + 1);
   localparam int SUM_W  = $clog2(NUM_READINGS * 255 + 1);
   localparam int STEP_W = $clog2(SUM_W);
   localparam int BLK_W  = $clog2(BLINK_TICKS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_CTRL = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [ADC_W-1:0]    adc_ff, adc_in;
   logic [TEMP_W-1:0]   cur_ff, cur_in;
   logic [TEMP_W-1:0]   avg_ff, avg_in;
   logic [IDX_W-1:0]    write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]    valid_count_ff, valid_count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                heating_ff, heating_in;
   logic                cooling_ff, cooling_in;
   logic                led_ff, led_in;
   logic [BLK_W-1:0]    blink_ff, blink_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic                control_enable_ff, control_enable_in;
   logic [BAND_W-1:0]   band_ff, band_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_heater_ff, rsp_heater_in;
   logic                rsp_cooler_ff, rsp_cooler_in;
   logic                rsp_led_ff, rsp_led_in;
   logic [TEMP_W-1:0]   rsp_cur_ff, rsp_cur_in;
   logic [TEMP_W-1:0]   rsp_avg_ff, rsp_avg_in;

   logic [TEMP_W-1:0] deg;
   logic              ring_wr_en;
   logic [TEMP_W-1:0] ring_rd_data;
   logic [SUM_W-1:0]  alu_a, alu_b, alu_y;
   logic              alu_sub, alu_cout;
   logic [CNT_W:0]    div_shift;
   logic              sum_last;
   logic              ring_ptrs_ok;

   logic [TARGET_W-1:0] low_val;
   logic                low_ok, le_low, ge_high;
   logic [TEMP_W-1:0]   high_val;
   logic                heat_n, cool_n, led_n;
   logic [BLK_W-1:0]    blink_inc;

   assign deg        = to_degrees(adc_ff);
   assign ring_wr_en = (state_ff == S_CONV);
   assign div_shift  = {rem_ff, acc_ff[SUM_W-1]};
   assign sum_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == valid_count_ff;
   assign ring_ptrs_ok = (valid_count_ff <= CNT_W'(NUM_READINGS))
                         && (CNT_W'(write_slot_ff) < CNT_W'(NUM_READINGS));

   thah_ring #(
      .NUM_READINGS(NUM_READINGS),
      .IDX_W(IDX_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_wr_en),
      .wr_addr(write_slot_ff),
      .wr_data(deg),
      .rd_addr(idx_ff),
      .rd_data(ring_rd_data)
   );

   always_comb begin
      if (state_ff == S_DIV) begin
         alu_a   = SUM_W'(div_shift);
         alu_b   = SUM_W'(valid_count_ff);
         alu_sub = 1'b1;
      end else begin
         alu_a   = acc_ff;
         alu_b   = SUM_W'(ring_rd_data);
         alu_sub = 1'b0;
      end
   end

   thah_alu #(
      .W(SUM_W)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .y   (alu_y),
      .cout(alu_cout)
   );

   // hysteresis decision on the finished average
   always_comb begin
      low_ok   = target_ff >= TARGET_W'(band_ff);
      low_val  = target_ff - TARGET_W'(band_ff);
      le_low   = low_ok && (acc_ff[TEMP_W-1:0] <= TEMP_W'(low_val));
      high_val = TEMP_W'(target_ff) + TEMP_W'(band_ff);
      ge_high  = acc_ff[TEMP_W-1:0] >= high_val;
      heat_n   = heating_ff;
      cool_n   = cooling_ff;
      led_n    = led_ff;
      blink_in = blink_ff;
      if (!heating_ff && !cooling_ff) begin
         if (le_low) begin
            heat_n = 1'b1;
         end else begin
            cool_n = 1'b1;
         end
      end else if (heating_ff && ge_high) begin
         heat_n = 1'b0;
         cool_n = 1'b1;
         led_n  = 1'b1;
      end else if (cooling_ff && le_low) begin
         heat_n = 1'b1;
         cool_n = 1'b0;
      end
      blink_inc = blink_ff + BLK_W'(1);
      if (heat_n) begin
         if (blink_inc >= BLK_W'(BLINK_TICKS)) begin
            led_n    = !led_n;
            blink_in = '0;
         end else begin
            blink_in = blink_inc;
         end
      end
      if (state_ff != S_CTRL) begin
         blink_in = blink_ff;
      end
   end

   always_comb begin
      state_in          = state_ff;
      adc_in            = adc_ff;
      cur_in            = cur_ff;
      avg_in            = avg_ff;
      write_slot_in     = write_slot_ff;
      valid_count_in    = valid_count_ff;
      idx_in            = idx_ff;
      pend_in           = pend_ff;
      acc_in            = acc_ff;
      rem_in            = rem_ff;
      step_in           = step_ff;
      heating_in        = heating_ff;
      cooling_in        = cooling_ff;
      led_in            = led_ff;
      target_in         = target_ff;
      control_enable_in = control_enable_ff;
      band_in           = band_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_heater_in     = rsp_heater_ff;
      rsp_cooler_in     = rsp_cooler_ff;
      rsp_led_in        = rsp_led_ff;
      rsp_cur_in        = rsp_cur_ff;
      rsp_avg_in        = rsp_avg_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_TEMP:    target_in = csr_wdata[TARGET_W-1:0];
            CSR_CONTROL_ENABLE: control_enable_in = csr_wdata[0];
            CSR_HYST_BAND:      band_in = csr_wdata[BAND_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               adc_in   = req_adc_sample;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cur_in = deg;
            avg_in = '0;
            if (CNT_W'(write_slot_ff) == CNT_W'(NUM_READINGS - 1)) begin
               write_slot_in = '0;
            end else begin
               write_slot_in = write_slot_ff + IDX_W'(1);
            end
            if (valid_count_ff != CNT_W'(NUM_READINGS)) begin
               valid_count_in = valid_count_ff + CNT_W'(1);
            end
            idx_in  = '0;
            pend_in = 1'b0;
            acc_in  = '0;
            state_in = control_enable_ff ? S_SUM : S_DONE;
         end
         S_SUM: begin
            if (pend_ff) begin
               acc_in = alu_y;
            end
            pend_in = 1'b1;
            if (sum_last) begin
               state_in = S_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_TAIL: begin
            acc_in   = alu_y;
            rem_in   = '0;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (alu_cout) begin
               rem_in = alu_y[CNT_W-1:0];
            end else begin
               rem_in = div_shift[CNT_W-1:0];
            end
            acc_in = {acc_ff[SUM_W-2:0], alu_cout};
            if (step_ff == '0) begin
               state_in = S_CTRL;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_CTRL: begin
            avg_in     = acc_ff[TEMP_W-1:0];
            heating_in = heat_n;
            cooling_in = cool_n;
            led_in     = led_n;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_heater_in = heating_ff;
               rsp_cooler_in = cooling_ff;
               rsp_led_in    = led_ff;
               rsp_cur_in    = cur_ff;
               rsp_avg_in    = avg_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         write_slot_ff     <= '0;
         valid_count_ff    <= '0;
         heating_ff        <= 1'b0;
         cooling_ff        <= 1'b0;
         led_ff            <= 1'b0;
         blink_ff          <= '0;
         target_ff         <= TARGET_RESET;
         control_enable_ff <= 1'b0;
         band_ff           <= BAND_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         write_slot_ff     <= write_slot_in;
         valid_count_ff    <= valid_count_in;
         heating_ff        <= heating_in;
         cooling_ff        <= cooling_in;
         led_ff            <= led_in;
         blink_ff          <= blink_in;
         target_ff         <= target_in;
         control_enable_ff <= control_enable_in;
         band_ff           <= band_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      adc_ff        <= adc_in;
      cur_ff        <= cur_in;
      avg_ff        <= avg_in;
      idx_ff        <= idx_in;
      pend_ff       <= pend_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rsp_heater_ff <= rsp_heater_in;
      rsp_cooler_ff <= rsp_cooler_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_avg_ff    <= rsp_avg_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heater_drive = rsp_heater_ff;
   assign rsp_cooler_drive = rsp_cooler_ff;
   assign rsp_status_led   = rsp_led_ff;
   assign rsp_current_temp = rsp_cur_ff;
   assign rsp_average_temp = rsp_avg_ff;

   `THAH_ASSERT(a_drive_exclusive, !(heating_ff && cooling_ff), "heater and cooler both on")
   `THAH_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready after accept")
   `THAH_ASSERT(a_ring_ptrs, ring_ptrs_ok, "ring pointer out of range")

endmodule

[test/tb_thermostat_average_hysteresis.sv]
module tb_thermostat_average_hysteresis;
   timeunit 1ns;
   timeprecision 1ps;
   import thah_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 64;
   localparam int REPORT_LIMIT  = 10;
   localparam int DEG_NUM       = 488;
   localparam int DEG_DEN       = 1000;
   localparam int TEMP_MAX      = 255;
   localparam int ADC_MAX       = 1023;
   localparam int RING_DEPTH    = NUM_READINGS_DEF;
   localparam int BLINK_LIMIT   = BLINK_TICKS_DEF;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic              heater;
      logic              cooler;
      logic              led;
      logic [TEMP_W-1:0] current;
      logic [TEMP_W-1:0] average;
   } thermo_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [ADC_W-1:0]      adc;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      thermo_result_type     golden;
   } stim_row_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic                enable;
      logic [BAND_W-1:0]   band;
      logic                pick_random;
      idle_mode_type       mode;
      logic [9:0]          items;
      logic                holdoff;
   } phase_type;

   localparam thermo_result_type NO_RESULT = '0;

   localparam stim_row_type DIRECTED [24] = '{
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0,   8'd0}},
      '{ROW_SAMPLE, 10'd1023, '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd255, 8'd0}},
      '{ROW_SAMPLE, 10'd522,  '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd254, 8'd0}},
      '{ROW_SAMPLE, 10'd523,  '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd255, 8'd0}},
      '{ROW_SAMPLE, 10'd3,    '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd1,   8'd0}},
      '{ROW_SAMPLE, 10'h155,  '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'h2AA,  '0, '0, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_UNMAPPED,       7'h7F, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_CONTROL_ENABLE, 7'h01, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd100,  '0, '0, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_TARGET_TEMP,    7'h00, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_HYST_BAND,      7'h7F, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd1023, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_TARGET_TEMP,    7'h7F, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_HYST_BAND,      7'h00, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd1023, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd0,    '0, '0, 1'b0, NO_RESULT},
      '{ROW_CSR,    '0, CSR_CONTROL_ENABLE, 7'h7E, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd512,  '0, '0, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, 10'd1022, '0, '0, 1'b0, NO_RESULT}
   };

   localparam phase_type PHASES [9] = '{
      '{7'd60,  1'b1, 5'd5,  1'b0, IDLE_NONE,     10'd60, 1'b0},
      '{7'd35,  1'b1, 5'd0,  1'b0, IDLE_SENDER,   10'd60, 1'b0},
      '{7'd75,  1'b1, 5'd20, 1'b0, IDLE_RECEIVER, 10'd60, 1'b0},
      '{7'd0,   1'b1, 5'd0,  1'b1, IDLE_BOTH,     10'd60, 1'b0},
      '{7'd0,   1'b1, 5'd31, 1'b0, IDLE_NONE,     10'd40, 1'b0},
      '{7'd127, 1'b1, 5'd31, 1'b0, IDLE_SENDER,   10'd40, 1'b0},
      '{7'd60,  1'b0, 5'd5,  1'b0, IDLE_BOTH,     10'd40, 1'b0},
      '{7'd50,  1'b1, 5'd3,  1'b0, IDLE_NONE,     10'd60, 1'b1},
      '{7'd0,   1'b1, 5'd0,  1'b1, IDLE_RECEIVER, 10'd60, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADC_W-1:0]      req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_heater_drive;
   logic                  rsp_cooler_drive;
   logic                  rsp_status_led;
   logic [TEMP_W-1:0]     rsp_current_temp;
   logic [TEMP_W-1:0]     rsp_average_temp;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   thermostat_average_hysteresis dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heater_drive (rsp_heater_drive),
      .rsp_cooler_drive (rsp_cooler_drive),
      .rsp_status_led   (rsp_status_led),
      .rsp_current_temp (rsp_current_temp),
      .rsp_average_temp (rsp_average_temp),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // thermostat state mirrored from the transactions seen at the ports
   logic [TEMP_W-1:0]   ring [RING_DEPTH];
   int                  slot;
   int                  fill;
   logic                heating;
   logic                cooling;
   int                  blink;
   logic                led;
   logic [TARGET_W-1:0] cfg_target;
   logic                cfg_enable;
   logic [BAND_W-1:0]   cfg_band;

   thermo_result_type pending_results [$];

   idle_mode_type     idle_mode = IDLE_NONE;
   logic              offer_typed = 1'b0;
   thermo_result_type offer_golden = '0;
   int                holdoff_requests = 0;
   int                holdoffs_served = 0;
   int                walk_temp = 0;
   int                walk_dir = 1;

   int fault_count = 0;
   int samples_accepted = 0;
   int csr_writes = 0;
   int heater_results = 0;
   int cooler_results = 0;
   int led_changes = 0;
   logic last_led = 1'b0;

   function automatic void reset_thermostat();
      foreach (ring[i]) ring[i] = '0;
      slot = 0;
      fill = 0;
      heating = 1'b0;
      cooling = 1'b0;
      blink = 0;
      led = 1'b0;
      cfg_target = TARGET_RESET;
      cfg_enable = 1'b0;
      cfg_band = BAND_RESET;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TARGET_TEMP:    cfg_target = data[TARGET_W-1:0];
         CSR_CONTROL_ENABLE: cfg_enable = data[0];
         CSR_HYST_BAND:      cfg_band = data[BAND_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic thermo_result_type predict_tick(input logic [ADC_W-1:0] adc);
      thermo_result_type r;
      int deg;
      int sum;
      int avg;
      int low;
      int high;
      deg = int'(adc) * DEG_NUM / DEG_DEN;
      if (deg > TEMP_MAX) deg = TEMP_MAX;
      ring[slot] = TEMP_W'(deg);
      slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
      if (fill < RING_DEPTH) fill++;
      avg = 0;
      if (cfg_enable) begin
         sum = 0;
         for (int i = 0; i < fill; i++) sum += int'(ring[i]);
         avg = (fill == 0) ? 0 : sum / fill;
         low = int'(cfg_target) - int'(cfg_band);
         high = int'(cfg_target) + int'(cfg_band);
         if (!heating && !cooling) begin
            if (avg <= low) heating = 1'b1;
            else cooling = 1'b1;
         end else if (heating && avg >= high) begin
            heating = 1'b0;
            cooling = 1'b1;
            led = 1'b1;
         end else if (cooling && avg <= low) begin
            heating = 1'b1;
            cooling = 1'b0;
         end
         if (heating) begin
            blink++;
            if (blink >= BLINK_LIMIT) begin
               led = !led;
               blink = 0;
            end
         end
      end
      r.heater = heating;
      r.cooler = cooling;
      r.led = led;
      r.current = TEMP_W'(deg);
      r.average = TEMP_W'(avg);
      return r;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 82;
         IDLE_BOTH:   return 20;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 82;
         IDLE_BOTH:     return 20;
         default:       return 0;
      endcase
   endfunction

   // sweep the temperature across both switching thresholds, with some noise
   function automatic logic [ADC_W-1:0] next_adc();
      int roll;
      int code;
      int lo_turn;
      int hi_turn;
      roll = $urandom_range(0, 99);
      if (roll < 4) return (roll < 2) ? '0 : '1;
      if (roll < 14) return ADC_W'($urandom);
      lo_turn = int'(cfg_target) - int'(cfg_band) - 6;
      hi_turn = int'(cfg_target) + int'(cfg_band) + 6;
      if (lo_turn < 0) lo_turn = 0;
      if (hi_turn > TEMP_MAX) hi_turn = TEMP_MAX;
      walk_temp += walk_dir * int'($urandom_range(0, 4));
      if (walk_temp < 0) walk_temp = 0;
      if (walk_temp > TEMP_MAX) walk_temp = TEMP_MAX;
      if (walk_temp >= hi_turn) walk_dir = -1;
      if (walk_temp <= lo_turn) walk_dir = 1;
      code = (walk_temp * DEG_DEN + DEG_NUM - 1) / DEG_NUM + int'($urandom_range(0, 2));
      if (code > ADC_MAX) code = ADC_MAX;
      return ADC_W'(code);
   endfunction

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_for_drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   task automatic offer_sample(input logic [ADC_W-1:0] adc, input logic typed,
                               input thermo_result_type golden);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_adc_sample = adc;
      offer_typed = typed;
      offer_golden = golden;
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (holdoff_requests > holdoffs_served) begin
            rsp_ready = 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
            holdoffs_served++;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= receiver_stall_pct());
         end
      end
   end

   always @(posedge clock) begin
      thermo_result_type golden;
      thermo_result_type seen;
      if (reset) begin
         reset_thermostat();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            golden = predict_tick(req_adc_sample);
            if (offer_typed) golden = offer_golden;
            pending_results.push_back(golden);
            samples_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_heater_drive, rsp_cooler_drive, rsp_status_led,
                     rsp_current_temp, rsp_average_temp};
            if (seen.heater) heater_results++;
            if (seen.cooler) cooler_results++;
            if (seen.led !== last_led) led_changes++;
            last_led = seen.led;
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected rsp: heater=%0b cooler=%0b led=%0b cur=%0d avg=%0d",
                           seen.heater, seen.cooler, seen.led, seen.current, seen.average);
            end else begin
               golden = pending_results.pop_front();
               if (seen.heater !== golden.heater || seen.cooler !== golden.cooler ||
                   seen.led !== golden.led || seen.current !== golden.current ||
                   seen.average !== golden.average) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display({"rsp mismatch: expected heater=%0b cooler=%0b led=%0b ",
                               "cur=%0d avg=%0d, got heater=%0b cooler=%0b led=%0b ",
                               "cur=%0d avg=%0d"},
                              golden.heater, golden.cooler, golden.led, golden.current,
                              golden.average, seen.heater, seen.cooler, seen.led,
                              seen.current, seen.average);
               end
            end
         end
      end
   end

   initial begin
      logic [TARGET_W-1:0] tgt;
      logic [BAND_W-1:0]   band;
      int                  n;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR)
            write_register(DIRECTED[i].idx, DIRECTED[i].data);
         else
            offer_sample(DIRECTED[i].adc, DIRECTED[i].typed, DIRECTED[i].golden);
      end

      foreach (PHASES[p]) begin
         tgt = PHASES[p].target;
         band = PHASES[p].band;
         if (PHASES[p].pick_random) begin
            tgt = TARGET_W'($urandom_range(0, 127));
            band = BAND_W'($urandom_range(0, 31));
         end
         write_register(CSR_TARGET_TEMP, CSR_DATA_W'(tgt));
         write_register(CSR_CONTROL_ENABLE,
                        {(CSR_DATA_W - 1)'($urandom), PHASES[p].enable});
         write_register(CSR_HYST_BAND, {(CSR_DATA_W - BAND_W)'($urandom), band});
         if (p == 0) write_register(CSR_UNMAPPED, CSR_DATA_W'($urandom));
         idle_mode = PHASES[p].mode;
         walk_temp = int'(tgt);
         walk_dir = ($urandom_range(0, 1) == 0) ? -1 : 1;
         if (PHASES[p].holdoff) holdoff_requests++;
         for (n = 0; n < int'(PHASES[p].items); n++) begin
            if (p == 0 && n == int'(PHASES[p].items) / 2) wait_for_drain();
            offer_sample(next_adc(), 1'b0, NO_RESULT);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         fault_count++;
         $display("%0d expected responses never arrived", pending_results.size());
      end
      $display("Ran %0d samples and %0d register writes over %0d settings and four idle modes,",
               samples_accepted, csr_writes, $size(PHASES));
      $display("with %0d heater-on, %0d cooler-on responses and %0d LED changes; %0d faults.",
               heater_results, cooler_results, led_changes, fault_count);
      if (fault_count == 0) begin
         $display("PASS thermostat_average_hysteresis");
      end else begin
         $display("FAIL thermostat_average_hysteresis");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting on handshakes");
      $display("FAIL thermostat_average_hysteresis");
      $finish;
   end

endmodule
